// ===== rtl/qcs_pkg.sv =====
// shared types and constants of the quadrature counter and speed estimator
package qcs_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // request codes of the input channel
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // counting pin codes
  localparam logic [1:0] SEL_PIN_A = 2'd0;
  localparam logic [1:0] SEL_PIN_B = 2'd1;

  // register indexes
  localparam logic [1:0] REG_EDGE_SEL = 2'd0;
  localparam logic [1:0] REG_MIN_INT  = 2'd1;
  localparam logic [1:0] REG_ALPHA    = 2'd2;

  localparam logic [1:0]  EDGE_SEL_RST = 2'd0;
  localparam logic [19:0] MIN_INT_RST  = 20'd10000;
  localparam logic [16:0] ALPHA_RST    = 17'd19661;

  localparam logic [16:0]        ALPHA_ONE  = 17'd65536;
  localparam logic signed [20:0] RATE_SCALE = 21'sd1000000;

  typedef struct packed {
    logic [1:0]  edge_sel;
    logic [19:0] min_int;
    logic [16:0] alpha;
  } cfg_t;

endpackage

// ===== rtl/qcs_regs.sv =====
// configuration registers behind the apb-style port
module qcs_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qcs_pkg::AddrW-1:0]  paddr,
  input  logic [qcs_pkg::DataW-1:0]  pwdata,
  output logic [qcs_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output qcs_pkg::cfg_t              cfg
);
  import qcs_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.edge_sel <= EDGE_SEL_RST;
      cfg_r.min_int  <= MIN_INT_RST;
      cfg_r.alpha    <= ALPHA_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_EDGE_SEL: cfg_r.edge_sel <= pwdata[1:0];
        REG_MIN_INT:  cfg_r.min_int  <= pwdata[19:0];
        REG_ALPHA:    cfg_r.alpha    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_EDGE_SEL: prdata = {30'd0, cfg_r.edge_sel};
      REG_MIN_INT:  prdata = {12'd0, cfg_r.min_int};
      REG_ALPHA:    prdata = {15'd0, cfg_r.alpha};
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/qcs_div.sv =====
// restoring divider, one quotient bit per cycle, 32-bit quotient
module qcs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num_hi,
  input  logic [31:0] num_lo,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  import qcs_pkg::*;

  logic [31:0] rem_r;
  logic [31:0] lo_r;
  logic [31:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  // num_hi is below den, so the remainder always stays within 32 bits
  assign trial = {rem_r, lo_r[31]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      rem_r <= num_hi;
      lo_r  <= num_lo;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? diff[31:0] : trial[31:0];
      lo_r  <= {lo_r[30:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = lo_r;

endmodule

// ===== rtl/quadrature_counter_speed_core.sv =====
// quadrature encoder channel: 2x tick counter with smoothed speed estimate
//
// input channel (in_valid/in_stall) takes one request per transaction:
// a pin sample, a speed update carrying a microsecond time, or a counter
// clear. every transaction yields exactly one result on the out channel
// (out_valid/out_stall) showing count, speed, active flag and whether the
// speed changed.
// samples, clears and updates that fall inside the minimum interval are
// handled in the idle state: the result is valid the cycle after acceptance.
// an update that takes effect runs through one shared multiplier and a
// bit-serial divider; the 32 divider steps dominate, and the divider is
// skipped when the rate saturates before it would start. in_stall stays high
// until the sequencer returns to idle.
// the output register holds a result while out_stall is high; a new request
// is taken only once the output register is free or being emptied.
// synchronous reset clears the count, prior count, prior time and speed,
// sets the stored pin levels to one and restores the register defaults.
// configuration sits on an apb-style port, registers at byte offsets 0, 4, 8.
module quadrature_counter_speed_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic                       in_pin_a,
  input  logic                       in_pin_b,
  input  logic [31:0]                in_now_us,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         out_count,
  output logic signed [31:0]         out_speed,
  output logic                       out_active,
  output logic                       out_speed_updated,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qcs_pkg::AddrW-1:0]  paddr,
  input  logic [qcs_pkg::DataW-1:0]  pwdata,
  output logic [qcs_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import qcs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_RATE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_RATE,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_SUM,
    ST_FIN
  } state_t;

  cfg_t cfg;

  state_t state_r, state_nxt;

  logic [31:0]        tick_r, tick_nxt;
  logic               last_a_r, last_a_nxt;
  logic               last_b_r, last_b_nxt;
  logic               seen_r, seen_nxt;
  logic [31:0]        prior_cnt_r, prior_cnt_nxt;
  logic [31:0]        prior_time_r, prior_time_nxt;
  logic signed [31:0] speed_r, speed_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [31:0]        d_r, d_nxt;
  logic [31:0]        dt_r, dt_nxt;
  logic signed [53:0] prod_r, prod_nxt;
  logic signed [49:0] acc_r, acc_nxt;
  logic signed [31:0] rate_r, rate_nxt;
  logic               ovf_r, ovf_nxt;

  logic               out_load;
  logic [31:0]        out_count_nxt;
  logic signed [31:0] out_speed_nxt;
  logic               out_active_nxt;
  logic               out_upd_nxt;
  logic [31:0]        out_count_r;
  logic signed [31:0] out_speed_r;
  logic               out_active_r;
  logic               out_upd_r;

  logic               out_free;
  logic               in_acc;
  logic [31:0]        dt;
  logic [19:0]        min_eff;
  logic [16:0]        alpha_eff;
  logic [16:0]        w_old;
  logic [31:0]        mag;

  logic signed [32:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [53:0] mul_p;

  logic [63:0]        num;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quo;

  logic [31:0]        q_cl;
  logic [49:0]        acc_mag;
  logic [49:0]        acc_rnd;
  logic [33:0]        acc_q;
  logic [31:0]        acc_cl;
  logic signed [31:0] speed_fin;

  qcs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qcs_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_hi (num[63:32]),
    .num_lo (num[31:0]),
    .den    (dt_r),
    .done   (div_done),
    .quo    (div_quo)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;

  assign dt        = in_now_us - prior_time_r;
  assign min_eff   = (cfg.min_int == 20'd0) ? 20'd1 : cfg.min_int;
  assign alpha_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
  assign w_old     = ALPHA_ONE - alpha_eff;
  assign mag       = d_r[31] ? (~d_r + 32'd1) : d_r;

  // shared multiplier: rate numerator, then both blend terms
  always_comb begin
    case (state_r)
      ST_MUL_RATE: begin
        mul_a = $signed({1'b0, mag});
        mul_b = RATE_SCALE;
      end
      ST_MUL_OLD: begin
        mul_a = {speed_r[31], speed_r};
        mul_b = $signed({4'd0, w_old});
      end
      ST_MUL_NEW: begin
        mul_a = {rate_r[31], rate_r};
        mul_b = $signed({4'd0, alpha_eff});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // ticks*256e6 plus half of dt for round-to-nearest
  assign num = {4'd0, prod_r[51:0], 8'd0} + {33'd0, dt_r[31:1]};

  // clamp quotient magnitude to 2^31
  assign q_cl = (ovf_r || (div_quo > 32'h8000_0000)) ? 32'h8000_0000 : div_quo;

  // blend result divided by 65536, nearest with ties away from zero
  assign acc_mag   = acc_r[49] ? (~acc_r + 50'd1) : acc_r;
  assign acc_rnd   = acc_mag + 50'd32768;
  assign acc_q     = acc_rnd[49:16];
  assign acc_cl    = (acc_q > 34'h0_8000_0000) ? 32'h8000_0000 : acc_q[31:0];
  assign speed_fin = acc_r[49] ? -$signed(acc_cl)
                   : (acc_cl[31] ? 32'sh7fff_ffff : $signed(acc_cl));

  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    last_a_nxt     = last_a_r;
    last_b_nxt     = last_b_r;
    seen_nxt       = seen_r;
    prior_cnt_nxt  = prior_cnt_r;
    prior_time_nxt = prior_time_r;
    speed_nxt      = speed_r;
    d_nxt          = d_r;
    dt_nxt         = dt_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    rate_nxt       = rate_r;
    ovf_nxt        = ovf_r;
    div_start      = 1'b0;
    out_load       = 1'b0;
    out_upd_nxt    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          case (in_req_type)
            REQ_SAMPLE: begin
              if (cfg.edge_sel == SEL_PIN_A && in_pin_a != last_a_r) begin
                tick_nxt = tick_r + ((in_pin_a == in_pin_b) ? 32'hffff_ffff : 32'd1);
              end else if (cfg.edge_sel == SEL_PIN_B && in_pin_b != last_b_r) begin
                tick_nxt = tick_r + ((in_pin_b == in_pin_a) ? 32'd1 : 32'hffff_ffff);
              end
              last_a_nxt = in_pin_a;
              last_b_nxt = in_pin_b;
              seen_nxt   = 1'b1;
            end
            REQ_UPDATE: begin
              if (dt >= {12'd0, min_eff}) begin
                out_load       = 1'b0;
                d_nxt          = tick_r - prior_cnt_r;
                dt_nxt         = dt;
                prior_cnt_nxt  = tick_r;
                prior_time_nxt = in_now_us;
                state_nxt      = ST_MUL_RATE;
              end
            end
            REQ_CLEAR: begin
              tick_nxt      = '0;
              prior_cnt_nxt = '0;
              speed_nxt     = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MUL_RATE: begin
        prod_nxt  = mul_p;
        state_nxt = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        // quotient of 2^32 or more saturates without running the divider
        ovf_nxt = num[63:32] >= dt_r;
        if (num[63:32] >= dt_r) begin
          state_nxt = ST_RATE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: begin
        if (div_done) begin
          state_nxt = ST_RATE;
        end
      end
      ST_RATE: begin
        rate_nxt  = d_r[31] ? -$signed(q_cl)
                  : (q_cl[31] ? 32'sh7fff_ffff : $signed(q_cl));
        state_nxt = ST_MUL_OLD;
      end
      ST_MUL_OLD: begin
        acc_nxt   = mul_p[49:0];
        state_nxt = ST_MUL_NEW;
      end
      ST_MUL_NEW: begin
        prod_nxt  = mul_p;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        acc_nxt   = acc_r + prod_r[49:0];
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          speed_nxt   = speed_fin;
          out_load    = 1'b1;
          out_upd_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_count_nxt  = tick_nxt;
    out_speed_nxt  = speed_nxt;
    out_active_nxt = seen_nxt;
    out_valid_nxt  = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      tick_r       <= '0;
      last_a_r     <= 1'b1;
      last_b_r     <= 1'b1;
      seen_r       <= 1'b0;
      prior_cnt_r  <= '0;
      prior_time_r <= '0;
      speed_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      tick_r       <= tick_nxt;
      last_a_r     <= last_a_nxt;
      last_b_r     <= last_b_nxt;
      seen_r       <= seen_nxt;
      prior_cnt_r  <= prior_cnt_nxt;
      prior_time_r <= prior_time_nxt;
      speed_r      <= speed_nxt;
    end
    d_r    <= d_nxt;
    dt_r   <= dt_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    rate_r <= rate_nxt;
    ovf_r  <= ovf_nxt;
    if (out_load) begin
      out_count_r  <= out_count_nxt;
      out_speed_r  <= out_speed_nxt;
      out_active_r <= out_active_nxt;
      out_upd_r    <= out_upd_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_count         = $signed(out_count_r);
  assign out_speed         = out_speed_r;
  assign out_active        = out_active_r;
  assign out_speed_updated = out_upd_r;

  // divider finishes only while the sequencer waits for it
  a_div_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV_RUN)
    else $error("divider done outside of its wait state");

  // a clear shows zero count and speed without an update flag
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req_type == REQ_CLEAR) |=>
      (out_valid && out_count == 32'sd0 && out_speed == 32'sd0 && !out_speed_updated))
    else $error("clear transaction gave a wrong result");

  // finishing an update always delivers a flagged result
  a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=>
      (out_valid && out_speed_updated && state_r == ST_IDLE))
    else $error("speed update result missing");

endmodule
